### design/lrubc_pkg.sv
// shared types and constants of the lru block buffer cache
// used by the controller, the datapath, the top level and the port checker

package lrubc_pkg;

	// default sizes, handed down from the top level
	localparam int NUM_BUFFERS_DEF = 16;
	localparam int BLOCK_BITS_DEF  = 24;

	// input beat layout: tdata = block_number, buffer_id; tuser = command
	localparam int BLK_FLD_W   = 24;
	localparam int BLK_LSB     = 0;
	localparam int ID_FLD_W    = 4;
	localparam int ID_LSB      = 24;
	localparam int IN_TDATA_W  = 32;

	// output beat layout: tdata = granted_buffer, hit, status
	localparam int GNT_FLD_W   = 4;
	localparam int STAT_FLD_W  = 2;
	localparam int OUT_USED_W  = GNT_FLD_W + 1 + STAT_FLD_W;
	localparam int OUT_TDATA_W = 8;

	// command codes on tuser
	localparam logic CMD_GET     = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// result status codes
	typedef enum logic [STAT_FLD_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_NOT_HELD = 2'd2
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_SHIFT,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic do_release;
		logic set_empty;
		logic scan;
		logic shift;
		logic commit;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_rel;
		logic empty;
		logic scan_done;
		logic shift_done;
	} dp_stat_t;

endpackage

### design/lrubc_ctrl.sv
// controller state machine of the lru block buffer cache
// depends on lrubc_pkg; drives the datapath through dp_cmd_t

module lrubc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  lrubc_pkg::dp_stat_t dstat,
	output lrubc_pkg::dp_cmd_t  dcmd
);
	import lrubc_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (dstat.is_rel || dstat.empty) state_nxt = ST_OUT;
				else state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (dstat.scan_done) state_nxt = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (dstat.shift_done) state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		dcmd = '0;
		unique case (state_q)
			ST_IDLE:     dcmd.capture = s_tvalid;
			ST_DISPATCH: begin
				dcmd.do_release = dstat.is_rel;
				dcmd.set_empty  = !dstat.is_rel && dstat.empty;
			end
			ST_SCAN:     dcmd.scan = 1'b1;
			ST_SHIFT: begin
				dcmd.shift  = 1'b1;
				dcmd.commit = dstat.shift_done;
			end
			ST_OUT:      dcmd.load_out = out_free;
			default:     dcmd = '0;
		endcase
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (dcmd.load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

### design/lrubc_dpath.sv
// datapath of the lru block buffer cache: free-order and tag memories,
// scan and compaction pipeline, held and valid flags; depends on lrubc_pkg

module lrubc_dpath #(
	parameter int NUM_BUFFERS = lrubc_pkg::NUM_BUFFERS_DEF,
	parameter int BLOCK_BITS  = lrubc_pkg::BLOCK_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [lrubc_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic                               s_tuser,
	output logic [lrubc_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  lrubc_pkg::dp_cmd_t                 dcmd,
	output lrubc_pkg::dp_stat_t                dstat
);
	import lrubc_pkg::*;

	localparam int ID_W  = $clog2(NUM_BUFFERS);
	localparam int CNT_W = $clog2(NUM_BUFFERS + 1);

	// captured request
	logic                  rel_q;
	logic [BLOCK_BITS-1:0] blk_q;
	logic [ID_FLD_W-1:0]   id_q;

	// pool state
	logic [CNT_W-1:0]       count_q;
	logic [NUM_BUFFERS-1:0] held_q;
	logic [NUM_BUFFERS-1:0] tvld_q;
	logic [NUM_BUFFERS-1:0] init_q;
	logic [ID_W-1:0]        fo_mem  [NUM_BUFFERS];
	logic [BLOCK_BITS-1:0]  tag_mem [NUM_BUFFERS];

	// read pipeline
	logic [CNT_W-1:0]      scan_ptr_q, sh_ptr_q;
	logic                  v_s1, init_s1;
	logic [ID_W-1:0]       idx_s1, fo_rd_s1, entry_s1;
	logic                  v_s2, tv_s2;
	logic [ID_W-1:0]       idx_s2, b_s2;
	logic [BLOCK_BITS-1:0] tag_s2;

	// result
	logic [ID_W-1:0]      oldest_q, res_buf_q;
	logic                 res_hit_q;
	logic [GNT_FLD_W-1:0] res_gnt_q;
	status_t              res_stat_q;
	logic [GNT_FLD_W-1:0] gnt_out_q;
	logic                 hit_out_q;
	status_t              stat_out_q;

	logic            scan_issue, shift_issue, rd_v;
	logic [ID_W-1:0] rd_addr, sel_buf, id_idx;
	logic            match, last, scan_done, shift_done;
	logic            in_range, rel_ok;

	// never-written free-order entries read as their own position
	assign entry_s1 = init_s1 ? fo_rd_s1 : idx_s1;

	// read issue, shared by scan and compaction
	assign scan_issue  = dcmd.scan && (scan_ptr_q < count_q) && !scan_done;
	assign shift_issue = dcmd.shift && (sh_ptr_q < count_q);
	assign rd_v        = scan_issue || shift_issue;
	assign rd_addr     = dcmd.scan ? scan_ptr_q[ID_W-1:0] : sh_ptr_q[ID_W-1:0];

	// tag compare at the end of the scan pipeline
	assign match     = v_s2 && tv_s2 && (tag_s2 == blk_q);
	assign last      = (CNT_W'(idx_s2) == count_q - CNT_W'(1));
	assign scan_done = dcmd.scan && v_s2 && (match || last);
	assign sel_buf   = (match || idx_s2 == '0) ? b_s2 : oldest_q;

	// compaction finished, only looked at while shifting
	assign shift_done = (sh_ptr_q >= count_q) && !v_s1;

	// release check
	assign id_idx   = ID_W'(id_q);
	assign in_range = 32'(id_q) < 32'(NUM_BUFFERS);
	assign rel_ok   = in_range && held_q[id_idx] && (count_q < CNT_W'(NUM_BUFFERS));

	assign dstat.is_rel     = rel_q;
	assign dstat.empty      = (count_q == '0);
	assign dstat.scan_done  = scan_done;
	assign dstat.shift_done = shift_done;

	assign m_tdata = OUT_TDATA_W'({stat_out_q, hit_out_q, gnt_out_q});

	// control state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= CNT_W'(NUM_BUFFERS);
			held_q     <= '0;
			tvld_q     <= '0;
			init_q     <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			scan_ptr_q <= '0;
			sh_ptr_q   <= '0;
		end else begin
			v_s1 <= rd_v;
			v_s2 <= v_s1 && dcmd.scan && !scan_done;
			if (dcmd.capture) scan_ptr_q <= '0;
			else if (scan_issue) scan_ptr_q <= scan_ptr_q + CNT_W'(1);
			if (scan_done) sh_ptr_q <= match ? CNT_W'(idx_s2) + CNT_W'(1) : CNT_W'(1);
			else if (shift_issue) sh_ptr_q <= sh_ptr_q + CNT_W'(1);
			// compaction write marks the entry as written
			if (dcmd.shift && v_s1) init_q[idx_s1 - ID_W'(1)] <= 1'b1;
			// release appends at the newest end
			if (dcmd.do_release && rel_ok) begin
				held_q[id_idx]                <= 1'b0;
				init_q[count_q[ID_W-1:0]]     <= 1'b1;
				count_q                       <= count_q + CNT_W'(1);
			end
			// get hands the buffer out
			if (dcmd.commit) begin
				held_q[res_buf_q] <= 1'b1;
				count_q           <= count_q - CNT_W'(1);
				if (!res_hit_q) tvld_q[res_buf_q] <= 1'b1;
			end
		end
	end

	// memories and payload registers
	always_ff @(posedge clk) begin
		if (dcmd.capture) begin
			rel_q <= (s_tuser == CMD_RELEASE);
			blk_q <= BLOCK_BITS'(s_tdata[BLK_LSB +: BLK_FLD_W]);
			id_q  <= s_tdata[ID_LSB +: ID_FLD_W];
		end
		// free-order memory
		fo_rd_s1 <= fo_mem[rd_addr];
		init_s1  <= init_q[rd_addr];
		idx_s1   <= rd_addr;
		if (dcmd.shift && v_s1) fo_mem[idx_s1 - ID_W'(1)] <= entry_s1;
		else if (dcmd.do_release && rel_ok) fo_mem[count_q[ID_W-1:0]] <= id_idx;
		// tag memory
		tag_s2 <= tag_mem[entry_s1];
		tv_s2  <= tvld_q[entry_s1];
		b_s2   <= entry_s1;
		idx_s2 <= idx_s1;
		if (dcmd.commit && !res_hit_q) tag_mem[res_buf_q] <= blk_q;
		// oldest free buffer, taken on a miss
		if (dcmd.scan && v_s2 && idx_s2 == '0) oldest_q <= b_s2;
		// result
		if (scan_done) begin
			res_buf_q  <= sel_buf;
			res_hit_q  <= match;
			res_gnt_q  <= GNT_FLD_W'(sel_buf);
			res_stat_q <= STAT_OK;
		end else if (dcmd.do_release) begin
			res_hit_q  <= 1'b0;
			res_gnt_q  <= id_q;
			res_stat_q <= rel_ok ? STAT_OK : STAT_NOT_HELD;
		end else if (dcmd.set_empty) begin
			res_hit_q  <= 1'b0;
			res_gnt_q  <= '0;
			res_stat_q <= STAT_EMPTY;
		end
		// output register
		if (dcmd.load_out) begin
			gnt_out_q  <= res_gnt_q;
			hit_out_q  <= res_hit_q;
			stat_out_q <= res_stat_q;
		end
	end

endmodule

### design/lru_block_buffer_cache.sv
// lru block buffer cache: a release, or a get on an empty pool, goes from dispatch
// straight to the output register; a get scans the free-order memory for the tag, stopping
// at the match on a hit and taking the oldest free buffer on a miss, then compacts it,
// both through the single read port of the free-order memory.
// one item at a time; the next beat is taken in the same cycle that m_tvalid rises, also while
// the previous result waits. arst_n frees all buffers in order 0 upward, no tag valid.

module lru_block_buffer_cache #(
	parameter int NUM_BUFFERS = lrubc_pkg::NUM_BUFFERS_DEF,
	parameter int BLOCK_BITS  = lrubc_pkg::BLOCK_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// block_number [23:0], buffer_id [27:24], zero [31:28]
	input  logic [lrubc_pkg::IN_TDATA_W-1:0]   s_tdata,
	// command
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// granted_buffer [3:0], hit [4], status [6:5], zero [7]
	output logic [lrubc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import lrubc_pkg::*;

	dp_cmd_t  dcmd;
	dp_stat_t dstat;

	// sequencing
	lrubc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.dstat    (dstat),
		.dcmd     (dcmd)
	);

	// storage and compare
	lrubc_dpath #(
		.NUM_BUFFERS (NUM_BUFFERS),
		.BLOCK_BITS  (BLOCK_BITS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.dcmd    (dcmd),
		.dstat   (dstat)
	);

endmodule

### design/lrubc_checker.sv
// port checker for the lru block buffer cache, bound to the top level
// depends on lrubc_pkg for the status codes

module lrubc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [lrubc_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import lrubc_pkg::*;

	logic [1:0] pend_q;
	logic       in_beat, out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	// items taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else if (in_beat && !out_beat) pend_q <= pend_q + 2'd1;
		else if (out_beat && !in_beat) pend_q <= pend_q - 2'd1;
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// every result beat answers a taken item
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> pend_q != 2'd0)
		else $error("result beat without request");

	// status is a known code
	a_stat_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:5] == STAT_OK || m_tdata[6:5] == STAT_EMPTY
			|| m_tdata[6:5] == STAT_NOT_HELD)
		else $error("bad status code");

	// errors never report a hit, empty pool grants buffer zero
	a_err_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6:5] != STAT_OK |-> !m_tdata[4]
			&& (m_tdata[6:5] != STAT_EMPTY || m_tdata[3:0] == 4'd0))
		else $error("hit or buffer on error result");

endmodule

bind lru_block_buffer_cache lrubc_checker u_lrubc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
